FILE: hdl/lav_pkg.sv
// shared types, constants and latency helper for the look-at view matrix block
package lav_pkg;

    // field width of every matrix entry word on the result ports
    localparam int FIELD_W = 32;

    // defaults for the top level parameters
    localparam int FRAC_BITS_DEF  = 16;
    localparam int WORD_WIDTH_DEF = 32;

    // the largest scaled magnitude of a nonzero vector sits in [2^(NORM_MAG-1), 2^NORM_MAG)
    localparam int NORM_MAG = 30;

    // stages through the vector normalizer:
    // magnitude, msb search, scale, square, sum, root steps, divide setup,
    // quotient steps, sign
    function automatic int norm_latency(input int frac);
        return frac + NORM_MAG + 9;
    endfunction

    // status that travels next to a normalized vector
    typedef struct packed {
        logic valid;
        logic zero;
    } t_nstat;

    // one finished matrix: four rows of four saturated words
    typedef struct packed {
        logic                                 degen;
        logic [3:0][3:0][FIELD_W-1:0]         ent;
    } t_mat;

endpackage

FILE: hdl/lav_norm.sv
// pipelined 3-vector normalizer: scale, squared length, root, per-component divide
module lav_norm #(
    parameter int IW        = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [IW-1:0]          i_v [3],
    output lav_pkg::t_nstat               o_stat,
    output logic signed [FRAC_BITS+1:0]   o_n [3]
);
    import lav_pkg::*;

    localparam int MW       = NORM_MAG;
    localparam int SW       = 2 * MW + 2;
    localparam int SQ_STEPS = SW / 2;
    localparam int PW       = $clog2(IW);
    localparam int NUMW     = MW + FRAC_BITS + 1;
    localparam int DSTEPS   = FRAC_BITS + 1;
    localparam int RW       = MW + 3;
    localparam int LENW     = MW + 2;
    localparam int NW       = FRAC_BITS + 2;
    localparam logic [PW-1:0] TOP_POS = PW'(MW - 1);

    // stage 1: magnitudes and sign
    logic          r_s1_v;
    logic [IW-1:0] r_s1_mag [3];
    logic          r_s1_neg [3];
    logic [IW-1:0] r_s1_or;

    // stage 2: position of the leading one
    logic          r_s2_v;
    logic [IW-1:0] r_s2_mag [3];
    logic          r_s2_neg [3];
    logic          r_s2_zero;
    logic [PW-1:0] r_s2_pos;
    logic [PW-1:0] n_pos;

    // stage 3: scaled magnitudes
    logic          r_s3_v;
    logic [MW-1:0] r_s3_m [3];
    logic          r_s3_neg [3];
    logic          r_s3_zero;
    logic [MW-1:0] n_m [3];

    // stage 4: squares
    logic            r_s4_v;
    logic [2*MW-1:0] r_s4_sq [3];
    logic [MW-1:0]   r_s4_m [3];
    logic            r_s4_neg [3];
    logic            r_s4_zero;

    // root steps, entry 0 holds the sum of squares
    logic          r_sq_v    [0:SQ_STEPS];
    logic [SW-1:0] r_sq_n    [0:SQ_STEPS];
    logic [SW-1:0] r_sq_r    [0:SQ_STEPS];
    logic [MW-1:0] r_sq_m    [0:SQ_STEPS][3];
    logic          r_sq_neg  [0:SQ_STEPS][3];
    logic          r_sq_zero [0:SQ_STEPS];

    // quotient steps, entry 0 holds the divide setup
    logic              r_dv_v    [0:DSTEPS];
    logic [RW-1:0]     r_dv_rem  [0:DSTEPS][3];
    logic [DSTEPS-1:0] r_dv_low  [0:DSTEPS][3];
    logic [DSTEPS-1:0] r_dv_q    [0:DSTEPS][3];
    logic [LENW-1:0]   r_dv_len  [0:DSTEPS];
    logic              r_dv_neg  [0:DSTEPS][3];
    logic              r_dv_zero [0:DSTEPS];

    // final signed result
    logic                 r_fin_v;
    logic                 r_fin_zero;
    logic signed [NW-1:0] r_fin_n [3];

    logic [NUMW-1:0] n_num [3];
    logic [LENW-1:0] len_w;

    // valid chain for the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else begin
            r_s1_v    <= i_valid;
            r_s2_v    <= r_s1_v;
            r_s3_v    <= r_s2_v;
            r_s4_v    <= r_s3_v;
            r_sq_v[0] <= r_s4_v;
        end
    end

    // absolute values and the or of all magnitudes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s1_neg[i] <= i_v[i][IW-1];
            r_s1_mag[i] <= i_v[i][IW-1] ? IW'(-i_v[i]) : IW'(i_v[i]);
        end
        r_s1_or <= (i_v[0][IW-1] ? IW'(-i_v[0]) : IW'(i_v[0]))
                 | (i_v[1][IW-1] ? IW'(-i_v[1]) : IW'(i_v[1]))
                 | (i_v[2][IW-1] ? IW'(-i_v[2]) : IW'(i_v[2]));
    end

    // leading one of the or gives the leading one of the largest magnitude
    always_comb begin
        n_pos = '0;
        for (int i = 0; i < IW; i++) begin
            if (r_s1_or[i]) begin
                n_pos = PW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_mag  <= r_s1_mag;
        r_s2_neg  <= r_s1_neg;
        r_s2_zero <= (r_s1_or == '0);
        r_s2_pos  <= n_pos;
    end

    // scale so the largest magnitude has its top bit at MW-1, halving truncates
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_s2_pos > TOP_POS) begin
                n_m[i] = MW'(r_s2_mag[i] >> (r_s2_pos - TOP_POS));
            end else begin
                n_m[i] = MW'({{MW{1'b0}}, r_s2_mag[i]} << (TOP_POS - r_s2_pos));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_m    <= n_m;
        r_s3_neg  <= r_s2_neg;
        r_s3_zero <= r_s2_zero;
    end

    // squares
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_s4_sq[i] <= r_s3_m[i] * r_s3_m[i];
        end
        r_s4_m    <= r_s3_m;
        r_s4_neg  <= r_s3_neg;
        r_s4_zero <= r_s3_zero;
    end

    // sum of squares seeds the root chain
    always_ff @(posedge i_clk) begin
        r_sq_n[0]    <= SW'(r_s4_sq[0]) + SW'(r_s4_sq[1]) + SW'(r_s4_sq[2]);
        r_sq_r[0]    <= '0;
        r_sq_m[0]    <= r_s4_m;
        r_sq_neg[0]  <= r_s4_neg;
        r_sq_zero[0] <= r_s4_zero;
    end

    // integer square root, one result bit per stage
    for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
        localparam int EXP = 2 * (SQ_STEPS - 1 - s);
        localparam logic [SW-1:0] BITV = {{(SW-1){1'b0}}, 1'b1} << EXP;
        logic [SW:0] sq_try;

        always_comb begin
            sq_try = {1'b0, r_sq_r[s]} + {1'b0, BITV};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[s+1] <= 1'b0;
            end else begin
                r_sq_v[s+1] <= r_sq_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if ({1'b0, r_sq_n[s]} >= sq_try) begin
                r_sq_n[s+1] <= r_sq_n[s] - SW'(sq_try);
                r_sq_r[s+1] <= (r_sq_r[s] >> 1) + BITV;
            end else begin
                r_sq_n[s+1] <= r_sq_n[s];
                r_sq_r[s+1] <= r_sq_r[s] >> 1;
            end
            r_sq_m[s+1]    <= r_sq_m[s];
            r_sq_neg[s+1]  <= r_sq_neg[s];
            r_sq_zero[s+1] <= r_sq_zero[s];
        end
    end

    // divide setup: numerator is magnitude scaled up plus half the length
    always_comb begin
        len_w = r_sq_r[SQ_STEPS][LENW-1:0];
        for (int i = 0; i < 3; i++) begin
            n_num[i] = (NUMW'(r_sq_m[SQ_STEPS][i]) << FRAC_BITS) + NUMW'(len_w >> 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dv_rem[0][i] <= RW'(n_num[i] >> DSTEPS);
            r_dv_low[0][i] <= n_num[i][DSTEPS-1:0];
            r_dv_q[0][i]   <= '0;
        end
        r_dv_len[0]  <= len_w;
        r_dv_neg[0]  <= r_sq_neg[SQ_STEPS];
        r_dv_zero[0] <= r_sq_zero[SQ_STEPS];
    end

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < DSTEPS; s++) begin : g_dv
        localparam int BIT_IDX = DSTEPS - 1 - s;
        logic [RW-1:0] dv_try [3];

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                dv_try[i] = {r_dv_rem[s][i][RW-2:0], r_dv_low[s][i][BIT_IDX]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[s+1] <= 1'b0;
            end else begin
                r_dv_v[s+1] <= r_dv_v[s];
            end
        end

        always_ff @(posedge i_clk) begin
            for (int i = 0; i < 3; i++) begin
                if (dv_try[i] >= RW'(r_dv_len[s])) begin
                    r_dv_rem[s+1][i] <= dv_try[i] - RW'(r_dv_len[s]);
                    r_dv_q[s+1][i]   <= {r_dv_q[s][i][DSTEPS-2:0], 1'b1};
                end else begin
                    r_dv_rem[s+1][i] <= dv_try[i];
                    r_dv_q[s+1][i]   <= {r_dv_q[s][i][DSTEPS-2:0], 1'b0};
                end
            end
            r_dv_low[s+1]  <= r_dv_low[s];
            r_dv_len[s+1]  <= r_dv_len[s];
            r_dv_neg[s+1]  <= r_dv_neg[s];
            r_dv_zero[s+1] <= r_dv_zero[s];
        end
    end

    // restore the sign
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else begin
            r_fin_v <= r_dv_v[DSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_fin_n[i] <= r_dv_neg[DSTEPS][i] ? -$signed({1'b0, r_dv_q[DSTEPS][i]})
                                              :  $signed({1'b0, r_dv_q[DSTEPS][i]});
        end
        r_fin_zero <= r_dv_zero[DSTEPS];
    end

    assign o_stat.valid = r_fin_v;
    assign o_stat.zero  = r_fin_zero;
    assign o_n          = r_fin_n;

endmodule

FILE: hdl/lav_rows.sv
// cross products, translation dot products and saturation into matrix rows
module lav_rows #(
    parameter int FRAC_BITS  = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lav_pkg::t_nstat              i_stat,
    input  logic signed [FRAC_BITS+1:0]  i_fn  [3],
    input  logic signed [FRAC_BITS+1:0]  i_un  [3],
    input  logic signed [31:0]           i_eye [3],
    output logic                         o_mvalid,
    output lav_pkg::t_mat                o_mat
);
    import lav_pkg::*;

    localparam int NW  = FRAC_BITS + 2;
    localparam int LW  = FRAC_BITS + 3;
    localparam int EW  = FRAC_BITS + 4;
    localparam int PW1 = 2 * NW;
    localparam int PW2 = LW + NW;
    localparam int TPW = EW + FIELD_W;
    localparam int TSW = EW + FIELD_W + 2;
    localparam int TW  = TSW - FRAC_BITS + 1;
    localparam int CW  = ((WORD_WIDTH > TW) ? WORD_WIDTH : TW) + 1;

    localparam logic signed [PW1:0] HALF_B = {{PW1{1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [PW2:0] HALF_D = {{PW2{1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [TSW-1:0] HALF_F = {{(TSW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [CW-1:0] SAT_HI =
        {{(CW-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [CW-1:0] ONE_Q = {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;

    // clamp to the word range and keep the field bits
    function automatic logic [FIELD_W-1:0] sat_w(input logic signed [CW-1:0] x);
        if (x > SAT_HI) begin
            return SAT_HI[FIELD_W-1:0];
        end else if (x < SAT_LO) begin
            return SAT_LO[FIELD_W-1:0];
        end else begin
            return x[FIELD_W-1:0];
        end
    endfunction

    // stage a: products for left = forward x up
    logic                  r_a_v;
    logic                  r_a_deg;
    logic signed [PW1-1:0] r_a_pp  [3];
    logic signed [PW1-1:0] r_a_pm  [3];
    logic signed [NW-1:0]  r_a_fn  [3];
    logic signed [31:0]    r_a_eye [3];

    // stage b: rounded left
    logic                 r_b_v;
    logic                 r_b_deg;
    logic signed [LW-1:0] r_b_left [3];
    logic signed [NW-1:0] r_b_fn   [3];
    logic signed [31:0]   r_b_eye  [3];
    logic signed [LW-1:0] n_left   [3];
    logic signed [PW1:0]  d_b      [3];
    logic signed [PW1:0]  rnd_b    [3];

    // stage c: products for true_up = left x forward
    logic                  r_c_v;
    logic                  r_c_deg;
    logic signed [PW2-1:0] r_c_pp   [3];
    logic signed [PW2-1:0] r_c_pm   [3];
    logic signed [LW-1:0]  r_c_left [3];
    logic signed [NW-1:0]  r_c_fn   [3];
    logic signed [31:0]    r_c_eye  [3];

    // stage d: rotation rows
    logic                 r_d_v;
    logic                 r_d_deg;
    logic signed [EW-1:0] r_d_row [3][3];
    logic signed [31:0]   r_d_eye [3];
    logic signed [PW2:0]  d_d     [3];
    logic signed [PW2:0]  rnd_d   [3];

    // stage e: translation products
    logic                  r_e_v;
    logic                  r_e_deg;
    logic signed [TPW-1:0] r_e_p   [3][3];
    logic signed [EW-1:0]  r_e_row [3][3];

    // stage f: translation sums
    logic                  r_f_v;
    logic                  r_f_deg;
    logic signed [TW-1:0]  r_f_t   [3];
    logic signed [EW-1:0]  r_f_row [3][3];
    logic signed [TSW-1:0] s_f     [3];
    logic signed [TSW-1:0] sh_f    [3];

    // stage g: saturated matrix
    logic r_g_v;
    t_mat r_g_mat;
    t_mat n_mat;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else begin
            r_a_v <= i_stat.valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    // left products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_a_pp[i] <= i_fn[(i+1)%3] * i_un[(i+2)%3];
            r_a_pm[i] <= i_fn[(i+2)%3] * i_un[(i+1)%3];
        end
        r_a_fn  <= i_fn;
        r_a_eye <= i_eye;
        r_a_deg <= i_stat.zero;
    end

    // left difference, round half up
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_b[i]    = (PW1+1)'(r_a_pp[i]) - (PW1+1)'(r_a_pm[i]);
            rnd_b[i]  = (d_b[i] + HALF_B) >>> FRAC_BITS;
            n_left[i] = LW'(rnd_b[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_left <= n_left;
        r_b_fn   <= r_a_fn;
        r_b_eye  <= r_a_eye;
        r_b_deg  <= r_a_deg;
    end

    // true_up products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_c_pp[i] <= r_b_left[(i+1)%3] * r_b_fn[(i+2)%3];
            r_c_pm[i] <= r_b_left[(i+2)%3] * r_b_fn[(i+1)%3];
        end
        r_c_left <= r_b_left;
        r_c_fn   <= r_b_fn;
        r_c_eye  <= r_b_eye;
        r_c_deg  <= r_b_deg;
    end

    // true_up rounding and row assembly
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_d[i]   = (PW2+1)'(r_c_pp[i]) - (PW2+1)'(r_c_pm[i]);
            rnd_d[i] = (d_d[i] + HALF_D) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_d_row[0][i] <= EW'(r_c_left[i]);
            r_d_row[1][i] <= EW'(rnd_d[i]);
            r_d_row[2][i] <= -EW'(r_c_fn[i]);
        end
        r_d_eye <= r_c_eye;
        r_d_deg <= r_c_deg;
    end

    // row times eye products
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                r_e_p[k][i] <= r_d_row[k][i] * r_d_eye[i];
            end
        end
        r_e_row <= r_d_row;
        r_e_deg <= r_d_deg;
    end

    // exact dot sum, round half up, negate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            s_f[k]  = TSW'(r_e_p[k][0]) + TSW'(r_e_p[k][1]) + TSW'(r_e_p[k][2]) + HALF_F;
            sh_f[k] = s_f[k] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_f_t[k] <= -TW'(sh_f[k]);
        end
        r_f_row <= r_e_row;
        r_f_deg <= r_e_deg;
    end

    // saturation, degenerate rows forced to zero, fixed last row
    always_comb begin
        n_mat.degen = r_f_deg;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n_mat.ent[k][i] = r_f_deg ? '0 : sat_w(CW'(r_f_row[k][i]));
            end
            n_mat.ent[k][3] = r_f_deg ? '0 : sat_w(CW'(r_f_t[k]));
        end
        n_mat.ent[3][0] = '0;
        n_mat.ent[3][1] = '0;
        n_mat.ent[3][2] = '0;
        n_mat.ent[3][3] = sat_w(ONE_Q);
    end

    always_ff @(posedge i_clk) begin
        r_g_mat <= n_mat;
    end

    assign o_mvalid = r_g_v;
    assign o_mat    = r_g_mat;

endmodule

FILE: hdl/look_at_view_matrix.sv
// top level of the look-at view matrix block: intake, normalizers, row math, row sequencer
//
// channel   direction  handshake              word
// command   in         start high, busy low   eye, target, up (9 x Q16.16)
// result    out        o_valid per word       row index, four columns, flags
//
// Each accepted command yields four result words, rows 0 to 3, on consecutive
// cycles. busy rises after each accept and stays high while the gap counter,
// loaded from the fixed row count, runs down, so commands are spaced to match
// the rows. The path from accept to row 0 runs through the root and quotient
// chains in the normalizers, the row math and the row sequencer. Reset is
// synchronous and clears only the valid chains, the busy count and the row
// sequencer control. Results cannot be stalled; the pipeline never holds.
module look_at_view_matrix #(
    parameter int FRAC_BITS  = lav_pkg::FRAC_BITS_DEF,
    parameter int WORD_WIDTH = lav_pkg::WORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_eye_x,
    input  logic signed [31:0] i_eye_y,
    input  logic signed [31:0] i_eye_z,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_target_z,
    input  logic signed [31:0] i_up_x,
    input  logic signed [31:0] i_up_y,
    input  logic signed [31:0] i_up_z,
    output logic               o_valid,
    output logic [1:0]         o_row_index,
    output logic signed [31:0] o_col0,
    output logic signed [31:0] o_col1,
    output logic signed [31:0] o_col2,
    output logic signed [31:0] o_col3,
    output logic               o_degenerate,
    output logic               o_last_row
);
    import lav_pkg::*;

    localparam int NORM_LAT = norm_latency(FRAC_BITS);
    localparam int NW       = FRAC_BITS + 2;
    localparam logic [1:0] LAST_ROW = 2'd3;

    logic                 accept;
    logic [1:0]           r_gap;
    logic [1:0]           n_gap;
    logic signed [32:0]   fwd [3];
    logic signed [31:0]   upv [3];
    logic signed [31:0]   r_eye_dl [0:NORM_LAT-1][3];
    t_nstat               stat_f;
    t_nstat               stat_u;
    t_nstat               stat_m;
    logic signed [NW-1:0] fn [3];
    logic signed [NW-1:0] un [3];
    logic                 mvalid;
    t_mat                 mat;

    t_mat                 r_mat;
    logic                 r_run;
    logic [1:0]           r_row;
    logic                 r_out_v;
    logic [1:0]           r_out_row;
    logic [3:0][31:0]     r_out_col;
    logic                 r_out_deg;

    // intake spacing: busy holds off start while the gap counter runs down
    assign accept = start & ~busy;
    assign busy   = (r_gap != 2'd0);

    always_comb begin
        if (accept) begin
            n_gap = LAST_ROW;
        end else if (r_gap != 2'd0) begin
            n_gap = r_gap - 2'd1;
        end else begin
            n_gap = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap <= 2'd0;
        end else begin
            r_gap <= n_gap;
        end
    end

    // forward direction and up vector
    always_comb begin
        fwd[0] = 33'(i_target_x) - 33'(i_eye_x);
        fwd[1] = 33'(i_target_y) - 33'(i_eye_y);
        fwd[2] = 33'(i_target_z) - 33'(i_eye_z);
        upv[0] = i_up_x;
        upv[1] = i_up_y;
        upv[2] = i_up_z;
    end

    lav_norm #(
        .IW        (33),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_v     (fwd),
        .o_stat  (stat_f),
        .o_n     (fn)
    );

    lav_norm #(
        .IW        (32),
        .FRAC_BITS (FRAC_BITS)
    ) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_v     (upv),
        .o_stat  (stat_u),
        .o_n     (un)
    );

    // eye point delayed to meet the normalized vectors
    always_ff @(posedge i_clk) begin
        r_eye_dl[0][0] <= i_eye_x;
        r_eye_dl[0][1] <= i_eye_y;
        r_eye_dl[0][2] <= i_eye_z;
        for (int k = 1; k < NORM_LAT; k++) begin
            r_eye_dl[k] <= r_eye_dl[k-1];
        end
    end

    assign stat_m.valid = stat_f.valid & stat_u.valid;
    assign stat_m.zero  = stat_f.zero | stat_u.zero;

    lav_rows #(
        .FRAC_BITS  (FRAC_BITS),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_rows (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stat   (stat_m),
        .i_fn     (fn),
        .i_un     (un),
        .i_eye    (r_eye_dl[NORM_LAT-1]),
        .o_mvalid (mvalid),
        .o_mat    (mat)
    );

    // row sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_row   <= 2'd0;
            r_out_v <= 1'b0;
        end else if (mvalid) begin
            r_run   <= 1'b1;
            r_row   <= 2'd1;
            r_out_v <= 1'b1;
        end else if (r_run) begin
            r_run   <= (r_row != LAST_ROW);
            r_row   <= r_row + 2'd1;
            r_out_v <= 1'b1;
        end else begin
            r_out_v <= 1'b0;
        end
    end

    // row sequencer words
    always_ff @(posedge i_clk) begin
        if (mvalid) begin
            r_mat     <= mat;
            r_out_row <= 2'd0;
            r_out_col <= mat.ent[0];
            r_out_deg <= mat.degen;
        end else begin
            r_out_row <= r_row;
            r_out_col <= r_mat.ent[r_row];
            r_out_deg <= r_mat.degen;
        end
    end

    assign o_valid      = r_out_v;
    assign o_row_index  = r_out_row;
    assign o_col0       = r_out_col[0];
    assign o_col1       = r_out_col[1];
    assign o_col2       = r_out_col[2];
    assign o_col3       = r_out_col[3];
    assign o_degenerate = r_out_deg;
    assign o_last_row   = (r_out_row == LAST_ROW);

endmodule
